[rtl/core/sbd_pkg.sv]
// ----------------------------------------------------------------------------
// sbd_pkg
// Shared types and codes for the script bytecode decoder.
// ----------------------------------------------------------------------------
package sbd_pkg;

    localparam int unsigned WORD_W   = 16;
    localparam int unsigned OPC_W    = 5;
    localparam int unsigned CLASS_W  = 5;
    localparam int unsigned BOP_W    = 5;
    localparam int unsigned KIDX_W   = 8;
    localparam int unsigned KCNT_W   = 9;
    localparam int unsigned ERR_W    = 2;
    localparam int unsigned WCNT_W   = 15;
    localparam int unsigned CFG_IDX_W = 1;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOWEST_ENTRY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KFUNC_COUNT  = 1'd1;

    localparam logic [WORD_W-1:0] LOWEST_ENTRY_RST = 16'hFFFF;
    localparam logic [KCNT_W-1:0] KFUNC_COUNT_RST  = 9'd176;

    // opcodes
    localparam logic [OPC_W-1:0] OPC_JMP      = 5'd0;
    localparam logic [OPC_W-1:0] OPC_SETRET   = 5'd1;
    localparam logic [OPC_W-1:0] OPC_PUSHRP   = 5'd2;
    localparam logic [OPC_W-1:0] OPC_PUSH_A   = 5'd3;
    localparam logic [OPC_W-1:0] OPC_PUSH_B   = 5'd4;
    localparam logic [OPC_W-1:0] OPC_PUSHVAR  = 5'd5;
    localparam logic [OPC_W-1:0] OPC_PUSHBPN  = 5'd6;
    localparam logic [OPC_W-1:0] OPC_PUSHBPA  = 5'd7;
    localparam logic [OPC_W-1:0] OPC_POPRP    = 5'd8;
    localparam logic [OPC_W-1:0] OPC_POPVAR   = 5'd9;
    localparam logic [OPC_W-1:0] OPC_POPBPN   = 5'd10;
    localparam logic [OPC_W-1:0] OPC_POPBPA   = 5'd11;
    localparam logic [OPC_W-1:0] OPC_ADDSP    = 5'd12;
    localparam logic [OPC_W-1:0] OPC_SUBSP    = 5'd13;
    localparam logic [OPC_W-1:0] OPC_KCALL    = 5'd14;
    localparam logic [OPC_W-1:0] OPC_IFNOTJMP = 5'd15;
    localparam logic [OPC_W-1:0] OPC_UNARY    = 5'd16;
    localparam logic [OPC_W-1:0] OPC_BINOP    = 5'd17;
    localparam logic [OPC_W-1:0] OPC_SRETJMP  = 5'd18;

    // instruction classes
    localparam logic [CLASS_W-1:0] CLS_JUMP      = 5'd0;
    localparam logic [CLASS_W-1:0] CLS_SETRET    = 5'd1;
    localparam logic [CLASS_W-1:0] CLS_PUSHRET   = 5'd2;
    localparam logic [CLASS_W-1:0] CLS_PUSHPOS   = 5'd3;
    localparam logic [CLASS_W-1:0] CLS_PUSH      = 5'd4;
    localparam logic [CLASS_W-1:0] CLS_PUSHVAR   = 5'd5;
    localparam logic [CLASS_W-1:0] CLS_PUSHBPNEG = 5'd6;
    localparam logic [CLASS_W-1:0] CLS_PUSHBPADD = 5'd7;
    localparam logic [CLASS_W-1:0] CLS_POPRET    = 5'd8;
    localparam logic [CLASS_W-1:0] CLS_POPPOS    = 5'd9;
    localparam logic [CLASS_W-1:0] CLS_POPVAR    = 5'd10;
    localparam logic [CLASS_W-1:0] CLS_POPBPNEG  = 5'd11;
    localparam logic [CLASS_W-1:0] CLS_POPBPADD  = 5'd12;
    localparam logic [CLASS_W-1:0] CLS_ADDSP     = 5'd13;
    localparam logic [CLASS_W-1:0] CLS_SUBSP     = 5'd14;
    localparam logic [CLASS_W-1:0] CLS_KCALL     = 5'd15;
    localparam logic [CLASS_W-1:0] CLS_IFNOTJMP  = 5'd16;
    localparam logic [CLASS_W-1:0] CLS_BOOLNEG   = 5'd17;
    localparam logic [CLASS_W-1:0] CLS_BINOP     = 5'd20;
    localparam logic [CLASS_W-1:0] CLS_SETRETJMP = 5'd21;

    localparam logic [WORD_W-1:0] UNARY_LAST = 16'd2;
    localparam logic [WORD_W-1:0] BINOP_LAST = 16'd17;

    // error codes
    localparam logic [ERR_W-1:0] ERR_NONE   = 2'd0;
    localparam logic [ERR_W-1:0] ERR_OPCODE = 2'd1;
    localparam logic [ERR_W-1:0] ERR_PARAM  = 2'd2;
    localparam logic [ERR_W-1:0] ERR_KFUNC  = 2'd3;

    // assembled instruction, front stage to decode
    typedef struct packed {
        logic [OPC_W-1:0]  opc;
        logic [WORD_W-1:0] param;
        logic [WORD_W-1:0] addr;
    } instr_t;

    // decoded fields
    typedef struct packed {
        logic [CLASS_W-1:0] op_class;
        logic [BOP_W-1:0]   binary_op;
        logic               has_operand;
        logic [WORD_W-1:0]  operand;
        logic               operand_signed;
        logic [WORD_W-1:0]  stack_change;
        logic [KIDX_W-1:0]  kernel_index;
        logic               low_target;
        logic [ERR_W-1:0]   error_code;
    } dec_t;

endpackage

[rtl/core/sbd_front.sv]
// ----------------------------------------------------------------------------
// sbd_front
// Input register stage: tracks word position, holds the first word of a
// two-word instruction and assembles opcode, operand and address.
// ----------------------------------------------------------------------------
module sbd_front
    import sbd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              code_valid,
    output logic              code_stall,
    input  logic [WORD_W-1:0] code_word,
    output logic              instr_valid,
    output instr_t            instr,
    input  logic              instr_take
);

    logic              s1_valid_reg, s1_valid_next;
    instr_t            s1_instr_reg, s1_instr_next;
    logic              awaiting_reg, awaiting_next;
    logic [WORD_W-1:0] held_word_reg, held_word_next;
    logic [WORD_W-1:0] held_addr_reg, held_addr_next;
    logic [WCNT_W-1:0] wcnt_reg, wcnt_next;

    logic              accept;
    logic              emit;
    logic [WORD_W-1:0] cur_addr;

    assign code_stall = s1_valid_reg && !instr_take;
    assign accept     = code_valid && !code_stall;
    assign cur_addr   = {wcnt_reg, 1'b0};

    always_comb
    begin
        emit           = 1'b0;
        s1_instr_next  = s1_instr_reg;
        awaiting_next  = awaiting_reg;
        held_word_next = held_word_reg;
        held_addr_next = held_addr_reg;
        wcnt_next      = wcnt_reg;
        if (accept)
        begin
            wcnt_next = wcnt_reg + 1'b1;
            if (awaiting_reg)
            begin
                emit                = 1'b1;
                awaiting_next       = 1'b0;
                s1_instr_next.opc   = held_word_reg[12:8];
                s1_instr_next.param = code_word;
                s1_instr_next.addr  = held_addr_reg;
            end
            else
            begin
                s1_instr_next.opc  = code_word[12:8];
                s1_instr_next.addr = cur_addr;
                priority if (code_word[15])
                begin
                    emit                = 1'b1;
                    s1_instr_next.opc   = OPC_JMP;
                    s1_instr_next.param = {1'b0, code_word[14:0]};
                end
                else if (code_word[14])
                begin
                    emit                = 1'b1;
                    s1_instr_next.param = {{8{code_word[7]}}, code_word[7:0]};
                end
                else if (code_word[13])
                begin
                    awaiting_next  = 1'b1;
                    held_word_next = code_word;
                    held_addr_next = cur_addr;
                end
                else
                begin
                    emit                = 1'b1;
                    s1_instr_next.param = '0;
                end
            end
        end
        if (emit)
            s1_valid_next = 1'b1;
        else if (instr_take)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            awaiting_reg  <= 1'b0;
            held_word_reg <= '0;
            held_addr_reg <= '0;
            wcnt_reg      <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            awaiting_reg  <= awaiting_next;
            held_word_reg <= held_word_next;
            held_addr_reg <= held_addr_next;
            wcnt_reg      <= wcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            s1_instr_reg <= s1_instr_next;
    end

    assign instr_valid = s1_valid_reg;
    assign instr       = s1_instr_reg;

endmodule

[rtl/core/sbd_decode.sv]
// ----------------------------------------------------------------------------
// sbd_decode
// Opcode decode: class, sub-operation, operand, stack change, kernel index,
// low-target flag and error code for one assembled instruction.
// ----------------------------------------------------------------------------
module sbd_decode
    import sbd_pkg::*;
(
    input  instr_t            instr,
    input  logic [WORD_W-1:0] lowest_entry,
    input  logic [KCNT_W-1:0] kfunc_count,
    output dec_t              dec
);

    logic [WORD_W-1:0] p;
    logic [WORD_W-1:0] target;

    assign p      = instr.param;
    assign target = {p[WORD_W-2:0], 1'b0};

    always_comb
    begin
        dec = '0;
        unique case (instr.opc)
            OPC_JMP, OPC_IFNOTJMP:
            begin
                dec.op_class     = (instr.opc == OPC_JMP) ? CLS_JUMP : CLS_IFNOTJMP;
                dec.has_operand  = 1'b1;
                dec.operand      = target;
                dec.low_target   = (target < lowest_entry);
                dec.stack_change = (instr.opc == OPC_JMP) ? '0 : '1;
            end
            OPC_SETRET:
            begin
                dec.op_class       = CLS_SETRET;
                dec.has_operand    = 1'b1;
                dec.operand_signed = 1'b1;
                dec.operand        = p;
            end
            OPC_PUSHRP:
            begin
                priority if (p == '0)
                begin
                    dec.op_class     = CLS_PUSHRET;
                    dec.stack_change = 16'd1;
                end
                else if (p == 16'd1)
                    dec.op_class = CLS_PUSHPOS;
                else
                    dec.error_code = ERR_PARAM;
            end
            OPC_PUSH_A, OPC_PUSH_B, OPC_PUSHVAR, OPC_PUSHBPN, OPC_PUSHBPA:
            begin
                dec.op_class       = (instr.opc <= OPC_PUSH_B) ? CLS_PUSH : instr.opc;
                dec.has_operand    = 1'b1;
                dec.operand_signed = 1'b1;
                dec.operand        = p;
                dec.stack_change   = 16'd1;
            end
            OPC_POPRP:
            begin
                priority if (p == '0)
                begin
                    dec.op_class     = CLS_POPRET;
                    dec.stack_change = '1;
                end
                else if (p == 16'd1)
                    dec.op_class = CLS_POPPOS;
                else
                    dec.error_code = ERR_PARAM;
            end
            OPC_POPVAR, OPC_POPBPN, OPC_POPBPA:
            begin
                dec.op_class       = instr.opc + 1'b1;
                dec.has_operand    = 1'b1;
                dec.operand_signed = 1'b1;
                dec.operand        = p;
                dec.stack_change   = '1;
            end
            OPC_ADDSP:
            begin
                dec.op_class       = CLS_ADDSP;
                dec.has_operand    = 1'b1;
                dec.operand_signed = 1'b1;
                dec.operand        = p;
                dec.stack_change   = -p;
            end
            OPC_SUBSP:
            begin
                dec.op_class       = CLS_SUBSP;
                dec.has_operand    = 1'b1;
                dec.operand_signed = 1'b1;
                dec.operand        = p;
                dec.stack_change   = p;
            end
            OPC_KCALL:
            begin
                dec.op_class     = CLS_KCALL;
                dec.kernel_index = p[KIDX_W-1:0];
                if ({1'b0, p[KIDX_W-1:0]} >= kfunc_count)
                    dec.error_code = ERR_KFUNC;
            end
            OPC_UNARY:
            begin
                if (p <= UNARY_LAST)
                    dec.op_class = CLS_BOOLNEG + {3'b000, p[1:0]};
                else
                    dec.error_code = ERR_PARAM;
            end
            OPC_BINOP:
            begin
                if (p <= BINOP_LAST)
                begin
                    dec.op_class     = CLS_BINOP;
                    dec.binary_op    = p[BOP_W-1:0];
                    dec.stack_change = '1;
                end
                else
                    dec.error_code = ERR_PARAM;
            end
            OPC_SRETJMP:
            begin
                dec.op_class     = CLS_SETRETJMP;
                dec.stack_change = 16'hFFFE;
            end
            default:
                dec.error_code = ERR_OPCODE;
        endcase
    end

endmodule

[rtl/core/script_bytecode_decoder.sv]
// Path: the accepted word that completes an instruction passes through the
//   input register and the result register to its decoded word on the
//   output; a prefix word of a two-word instruction gives no output.
// Throughput: one code word per cycle without stall, set by both registers.
// Reset: asynchronous, active low; clears pending state, counters and valids,
//   and loads config defaults (lowest entry 0xFFFF, function count 176).
// ----------------------------------------------------------------------------
// script_bytecode_decoder
// Decodes a stream of 16-bit script words into one decoded word per
// instruction.
// ----------------------------------------------------------------------------
module script_bytecode_decoder
    import sbd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    input  logic                 code_valid,
    output logic                 code_stall,
    input  logic [WORD_W-1:0]    code_word,
    output logic                 dec_valid,
    input  logic                 dec_stall,
    output logic [WORD_W-1:0]    instr_index,
    output logic [WORD_W-1:0]    byte_addr,
    output logic [CLASS_W-1:0]   op_class,
    output logic [BOP_W-1:0]     binary_op,
    output logic                 has_operand,
    output logic [WORD_W-1:0]    operand,
    output logic                 operand_signed,
    output logic signed [WORD_W-1:0] stack_change,
    output logic [KIDX_W-1:0]    kernel_index,
    output logic                 low_target,
    output logic [ERR_W-1:0]     error_code
);

    logic [WORD_W-1:0] lowest_entry_reg;
    logic [KCNT_W-1:0] kfunc_count_reg;
    logic [WORD_W-1:0] icnt_reg, icnt_next;
    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] out_index_reg;
    logic [WORD_W-1:0] out_addr_reg;
    dec_t              out_dec_reg;

    logic   instr_valid;
    instr_t instr;
    logic   instr_take;
    dec_t   dec;

    sbd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .code_valid  (code_valid),
        .code_stall  (code_stall),
        .code_word   (code_word),
        .instr_valid (instr_valid),
        .instr       (instr),
        .instr_take  (instr_take)
    );

    sbd_decode u_decode (
        .instr        (instr),
        .lowest_entry (lowest_entry_reg),
        .kfunc_count  (kfunc_count_reg),
        .dec          (dec)
    );

    assign instr_take = instr_valid && (!out_valid_reg || !dec_stall);

    always_comb
    begin
        icnt_next = icnt_reg;
        if (instr_take && (dec.error_code == ERR_NONE))
            icnt_next = icnt_reg + 1'b1;
        if (instr_take)
            out_valid_next = 1'b1;
        else if (!dec_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lowest_entry_reg <= LOWEST_ENTRY_RST;
            kfunc_count_reg  <= KFUNC_COUNT_RST;
            icnt_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_LOWEST_ENTRY: lowest_entry_reg <= cfg_data;
                    CFG_KFUNC_COUNT:  kfunc_count_reg  <= cfg_data[KCNT_W-1:0];
                    default:          ;
                endcase
            end
            icnt_reg      <= icnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (instr_take)
        begin
            out_index_reg <= icnt_reg;
            out_addr_reg  <= instr.addr;
            out_dec_reg   <= dec;
        end
    end

    assign dec_valid      = out_valid_reg;
    assign instr_index    = out_index_reg;
    assign byte_addr      = out_addr_reg;
    assign op_class       = out_dec_reg.op_class;
    assign binary_op      = out_dec_reg.binary_op;
    assign has_operand    = out_dec_reg.has_operand;
    assign operand        = out_dec_reg.operand;
    assign operand_signed = out_dec_reg.operand_signed;
    assign stack_change   = out_dec_reg.stack_change;
    assign kernel_index   = out_dec_reg.kernel_index;
    assign low_target     = out_dec_reg.low_target;
    assign error_code     = out_dec_reg.error_code;

endmodule
